@@ src/stt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the S-expression token splitter
// Holds the character codes, token kind codes, depth limit and the structs
// that carry lexer state and per-byte results between modules.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Widths of the item fields.
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int DEPTH_W = 8;

  // Depth saturation limit, clamped to what the depth field can hold.
  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_MAX_VAL = (1 << DEPTH_W) - 1;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT =
    DEPTH_W'((MAX_DEPTH > DEPTH_MAX_VAL) ? DEPTH_MAX_VAL : MAX_DEPTH);

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;

  // Token kind codes.
  localparam logic [KIND_W-1:0] KIND_ATOM   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STRING = 2'd2;

  // Lexer state carried from one byte to the next.
  typedef struct packed {
    logic               string_open;
    logic               token_open;
    logic [BYTE_W-1:0]  previous_byte;
    logic [BYTE_W-1:0]  byte_before_previous;
    logic [DEPTH_W-1:0] depth_count;
    logic               underflow_seen;
  } stt_state_t;

  // Result of one byte.
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               keep;
    logic               token_start;
    logic [KIND_W-1:0]  token_kind;
    logic               inside_string;
    logic [DEPTH_W-1:0] nesting_depth;
    logic               underflow_error;
  } stt_result_t;

endpackage
`default_nettype wire

@@ src/stt_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stt_in_if: source byte channel
// Valid/ready channel that carries one source byte per item.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic                      valid;
  logic                      ready;
  logic [stt_pkg::BYTE_W-1:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink   (input valid, input source_byte, output ready);
endinterface
`default_nettype wire

@@ src/stt_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stt_out_if: lexer result channel
// Valid/ready channel that carries the classification of one byte per item.
// ----------------------------------------------------------------------------
interface stt_out_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::BYTE_W-1:0]  out_byte;
  logic                        keep;
  logic                        token_start;
  logic [stt_pkg::KIND_W-1:0]  token_kind;
  logic                        inside_string;
  logic [stt_pkg::DEPTH_W-1:0] nesting_depth;
  logic                        underflow_error;

  modport source (output valid, output out_byte, output keep, output token_start,
                  output token_kind, output inside_string, output nesting_depth,
                  output underflow_error, input ready);
  modport sink   (input valid, input out_byte, input keep, input token_start,
                  input token_kind, input inside_string, input nesting_depth,
                  input underflow_error, output ready);
endinterface
`default_nettype wire

@@ src/stt_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stt_step: one lexer step
// Classifies one byte against the current lexer state and gives the next
// state together with the result of that byte. Purely combinational.
// ----------------------------------------------------------------------------
module stt_step (
  input  wire logic [stt_pkg::BYTE_W-1:0] cur_byte,
  input  wire stt_pkg::stt_state_t        state,
  output stt_pkg::stt_state_t             state_next,
  output stt_pkg::stt_result_t            result
);
  import stt_pkg::*;

  logic              escaped;
  logic              keep;
  logic              start;
  logic [KIND_W-1:0] kind;

  // A byte that follows '#' then a backslash is always plain token content.
  assign escaped = (state.byte_before_previous == CH_HASH) &&
                   (state.previous_byte == CH_BSLASH);

  // Token classification and state update.
  always_comb begin
    state_next = state;
    keep       = 1'b1;
    start      = 1'b0;
    kind       = KIND_ATOM;

    if (state.string_open) begin
      // Inside a string everything is kept; an unescaped quote closes it.
      kind = KIND_STRING;
      if ((cur_byte == CH_QUOTE) && !escaped) begin
        state_next.string_open = 1'b0;
        state_next.token_open  = 1'b0;
      end
    end else if (escaped) begin
      start                 = !state.token_open;
      state_next.token_open = 1'b1;
    end else if (cur_byte inside {CH_SPACE, CH_TAB, CH_NL}) begin
      // Separators are dropped and end any open atom.
      keep                  = 1'b0;
      state_next.token_open = 1'b0;
    end else if (cur_byte == CH_LPAREN) begin
      start                 = 1'b1;
      kind                  = KIND_PAREN;
      state_next.token_open = 1'b0;
      if (state.depth_count < DEPTH_LIMIT) begin
        state_next.depth_count = state.depth_count + DEPTH_W'(1);
      end
    end else if (cur_byte == CH_RPAREN) begin
      start                 = 1'b1;
      kind                  = KIND_PAREN;
      state_next.token_open = 1'b0;
      if (state.depth_count == '0) begin
        state_next.underflow_seen = 1'b1;
      end else begin
        state_next.depth_count = state.depth_count - DEPTH_W'(1);
      end
    end else if (cur_byte == CH_QUOTE) begin
      // A quote ends any atom and opens a new string token.
      start                  = 1'b1;
      kind                   = KIND_STRING;
      state_next.string_open = 1'b1;
      state_next.token_open  = 1'b1;
    end else begin
      start                 = !state.token_open;
      state_next.token_open = 1'b1;
    end

    // The lookback sees every byte of the stream, dropped ones too.
    state_next.byte_before_previous = state.previous_byte;
    state_next.previous_byte        = cur_byte;
  end

  // Result fields report the state after this byte.
  always_comb begin
    result.out_byte        = cur_byte;
    result.keep            = keep;
    result.token_start     = start;
    result.token_kind      = kind;
    result.inside_string   = state_next.string_open;
    result.nesting_depth   = state_next.depth_count;
    result.underflow_error = state_next.underflow_seen;
  end

endmodule
`default_nettype wire

@@ src/sexpr_token_splitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sexpr_token_splitter: byte-serial S-expression lexer
// Splits a source byte stream into tokens, one result item per byte, and
// tracks string state, parenthesis depth and a sticky underflow flag.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   -------  ---------  ------------------------------------------------------
//   source   in         source_byte
//   result   out        out_byte, keep, token_start, token_kind,
//                       inside_string, nesting_depth, underflow_error
//
// One item per cycle sustained while result.ready holds; a result item passes
// through the input register, then the result register, before it is offered.
// The lexer state is updated in the same cycle as the result register is
// loaded, so the state loop sets the rate. Synchronous reset clears the valid
// flags and the lexer state. A stalled result holds the result register and,
// once the input register is also full, deasserts source.ready.
module sexpr_token_splitter (
  input wire logic clk,
  input wire logic rst,
  stt_in_if.sink   source,
  stt_out_if.source result
);
  import stt_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  stt_result_t       out_data;
  stt_state_t        state;
  stt_state_t        state_next;
  stt_result_t       step_result;
  logic              advance;

  // The input register moves on when the result register is free or drained.
  assign advance      = in_valid && (!out_valid || result.ready);
  assign source.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (source.ready) begin
      in_valid <= source.valid;
    end
    if (source.ready && source.valid) begin
      in_byte <= source.source_byte;
    end
  end

  stt_step u_step (
    .cur_byte   (in_byte),
    .state      (state),
    .state_next (state_next),
    .result     (step_result)
  );

  // Lexer state, updated once per byte that moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= step_result;
    end
  end

  assign result.valid           = out_valid;
  assign result.out_byte        = out_data.out_byte;
  assign result.keep            = out_data.keep;
  assign result.token_start     = out_data.token_start;
  assign result.token_kind      = out_data.token_kind;
  assign result.inside_string   = out_data.inside_string;
  assign result.nesting_depth   = out_data.nesting_depth;
  assign result.underflow_error = out_data.underflow_error;

endmodule
`default_nettype wire
